// ===== src/rbo_pkg.sv =====
// Package for the RDS block offset checker: field widths, offset words,
// status and group type codes, and the syndrome function.
// No dependencies.
package rbo_pkg;

   localparam int BLOCK_W = 26;
   localparam int INFO_W  = 16;
   localparam int CHECK_W = 10;
   localparam int TYPE_W  = 5;
   localparam int SLOTS   = 4;

   // Offset words A to D
   localparam logic [CHECK_W-1:0] OFFSET_A = 10'h0FC;
   localparam logic [CHECK_W-1:0] OFFSET_B = 10'h198;
   localparam logic [CHECK_W-1:0] OFFSET_C = 10'h168;
   localparam logic [CHECK_W-1:0] OFFSET_D = 10'h1B4;

   // Slot codes
   localparam logic [1:0] SLOT_A = 2'd0;
   localparam logic [1:0] SLOT_B = 2'd1;
   localparam logic [1:0] SLOT_C = 2'd2;
   localparam logic [1:0] SLOT_D = 2'd3;

   // Block status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_CRC_FAIL = 2'd1;
   localparam logic [1:0] ST_DUP_SLOT = 2'd2;

   // Group type codes
   localparam logic [1:0] GT_0A      = 2'd0;
   localparam logic [1:0] GT_2A      = 2'd1;
   localparam logic [1:0] GT_UNKNOWN = 2'd2;
   localparam logic [1:0] GT_ERROR   = 2'd3;

   // Type code values in the top five info bits of block B
   localparam logic [TYPE_W-1:0] TYPE_CODE_0A = 5'b00000;
   localparam logic [TYPE_W-1:0] TYPE_CODE_2A = 5'b00100;

   localparam logic [1:0] LAST_BLOCK = 2'd3;

   // Columns of the parity matrix: x^(10+i) mod x^10+x^8+x^7+x^5+x^4+x^3+1
   localparam logic [CHECK_W-1:0] PARITY_COL [INFO_W] = '{
      10'h1B9, 10'h372, 10'h35D, 10'h303, 10'h3BF, 10'h2C7, 10'h037, 10'h06E,
      10'h0DC, 10'h1B8, 10'h370, 10'h359, 10'h30B, 10'h3AF, 10'h2E7, 10'h077
   };

   // Remainder of info * x^10, as an XOR of the columns of set info bits
   function automatic logic [CHECK_W-1:0] crc_rem(input logic [INFO_W-1:0] info);
      logic [CHECK_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < INFO_W; i++) begin
         if (info[i]) begin
            acc = acc ^ PARITY_COL[i];
         end
      end
      return acc;
   endfunction

endpackage

// ===== src/rds_block_offset_checker_core.sv =====
// RDS block offset checker: input register, syndrome and offset match,
// per-group slot tracking and result register. Depends on rbo_pkg.
// Each accepted item passes the input register, then the result register.
// Throughput: one item per cycle while rsp_ready is high; the input register
// refills while the result register is taken, so both sides stream without gaps.
// Reset: synchronous, active high; clears the valid flags and the group state.
module rds_block_offset_checker_core
   import rbo_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [BLOCK_W-1:0] req_block_word,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [INFO_W-1:0]  rsp_info_word,
   output logic [1:0]         rsp_slot_position,
   output logic [1:0]         rsp_block_status,
   output logic               rsp_group_done,
   output logic [1:0]         rsp_group_type
);

   // Input register
   logic               in_valid_ff;
   logic [BLOCK_W-1:0] in_word_ff;

   // Group state
   logic [1:0]        block_count_ff, block_count_in;
   logic [SLOTS-1:0]  filled_slots_ff, filled_slots_in;
   logic [TYPE_W-1:0] type_bits_ff, type_bits_in;
   logic              group_error_ff, group_error_in;

   // Result register
   logic              out_valid_ff;
   logic [INFO_W-1:0] info_ff;
   logic [1:0]        slot_ff, slot_in;
   logic [1:0]        status_ff, status_in;
   logic              done_ff, done_in;
   logic [1:0]        gtype_ff, gtype_in;

   logic               out_free;
   logic               advance;
   logic [INFO_W-1:0]  info;
   logic [CHECK_W-1:0] syndrome;
   logic               matched;
   logic [1:0]         match_slot;
   logic               dup;
   logic               err_now;

   // Handshake: result register frees when empty or taken
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_block_word;
      end
   end

   // Syndrome: remainder XOR received checkword, compared with each offset
   assign info     = in_word_ff[BLOCK_W-1:CHECK_W];
   assign syndrome = crc_rem(info) ^ in_word_ff[CHECK_W-1:0];

   always_comb begin
      matched    = 1'b1;
      match_slot = SLOT_A;
      priority if (syndrome == OFFSET_A) begin
         match_slot = SLOT_A;
      end else if (syndrome == OFFSET_B) begin
         match_slot = SLOT_B;
      end else if (syndrome == OFFSET_C) begin
         match_slot = SLOT_C;
      end else if (syndrome == OFFSET_D) begin
         match_slot = SLOT_D;
      end else begin
         matched = 1'b0;
      end
   end

   assign dup     = matched && filled_slots_ff[match_slot];
   assign err_now = !matched || dup;

   // Result fields and next group state
   always_comb begin
      filled_slots_in = filled_slots_ff;
      type_bits_in    = type_bits_ff;
      group_error_in  = group_error_ff || err_now;
      slot_in         = match_slot;
      status_in       = ST_OK;
      done_in         = 1'b0;
      gtype_in        = GT_0A;

      if (!matched) begin
         status_in = ST_CRC_FAIL;
         slot_in   = SLOT_A;
      end else if (dup) begin
         status_in = ST_DUP_SLOT;
      end else begin
         filled_slots_in[match_slot] = 1'b1;
         if (match_slot == SLOT_B) begin
            type_bits_in = info[INFO_W-1 -: TYPE_W];
         end
      end

      if (block_count_ff == LAST_BLOCK) begin
         done_in = 1'b1;
         priority if (group_error_in) begin
            gtype_in = GT_ERROR;
         end else if (type_bits_in == TYPE_CODE_0A) begin
            gtype_in = GT_0A;
         end else if (type_bits_in == TYPE_CODE_2A) begin
            gtype_in = GT_2A;
         end else begin
            gtype_in = GT_UNKNOWN;
         end
         block_count_in  = '0;
         filled_slots_in = '0;
         type_bits_in    = '0;
         group_error_in  = 1'b0;
      end else begin
         block_count_in = block_count_ff + 2'd1;
      end
   end

   // Group state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff  <= '0;
         filled_slots_ff <= '0;
         type_bits_ff    <= '0;
         group_error_ff  <= 1'b0;
      end else if (advance) begin
         block_count_ff  <= block_count_in;
         filled_slots_ff <= filled_slots_in;
         type_bits_ff    <= type_bits_in;
         group_error_ff  <= group_error_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         info_ff   <= info;
         slot_ff   <= slot_in;
         status_ff <= status_in;
         done_ff   <= done_in;
         gtype_ff  <= gtype_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_info_word     = info_ff;
   assign rsp_slot_position = slot_ff;
   assign rsp_block_status  = status_ff;
   assign rsp_group_done    = done_ff;
   assign rsp_group_type    = gtype_ff;

   // Checks
   a_group_wrap: assert property (@(posedge clock) disable iff (reset)
      advance && block_count_ff == LAST_BLOCK |=>
         block_count_ff == 2'd0 && filled_slots_ff == '0 && !group_error_ff && done_ff)
      else $error("group state not cleared after fourth block");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      advance && err_now && block_count_ff != LAST_BLOCK |=> group_error_ff)
      else $error("block error not recorded in group state");

   a_type_only_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !done_ff |-> gtype_ff == GT_0A)
      else $error("group type reported before end of group");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_word_ff))
      else $error("stalled input item lost");

endmodule

// ===== verif/tb_rds_block_offset_checker_core.sv =====
// Testbench for rds_block_offset_checker_core: drives RDS blocks, predicts slot,
// status and group type per item, and checks every result. Depends on rbo_pkg.
`timescale 1ns / 1ps

module tb_rds_block_offset_checker_core;
   import rbo_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [INFO_W-1:0] info;
      logic [1:0]        slot;
      logic [1:0]        status;
      logic              done;
      logic [1:0]        gtype;
   } blk_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [BLOCK_W-1:0] req_block_word = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [INFO_W-1:0]  rsp_info_word;
   logic [1:0]         rsp_slot_position;
   logic [1:0]         rsp_block_status;
   logic               rsp_group_done;
   logic [1:0]         rsp_group_type;

   // Predicted group state
   logic [1:0]         grp_count = '0;
   logic [SLOTS-1:0]   grp_slots = '0;
   logic [TYPE_W-1:0]  grp_type_bits = '0;
   logic               grp_err = 1'b0;

   blk_result_type     expected_results[$];
   int                 err_count = 0;
   int                 blocks_sent = 0;
   int unsigned        cycle_count = 0;
   bit                 idle_on = 1'b1;
   int                 hold_request = 0;
   int                 hold_left = 0;

   rds_block_offset_checker_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_block_word    (req_block_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_info_word     (rsp_info_word),
      .rsp_slot_position (rsp_slot_position),
      .rsp_block_status  (rsp_block_status),
      .rsp_group_done    (rsp_group_done),
      .rsp_group_type    (rsp_group_type)
   );

   always #5 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Offset word for a slot
   function automatic logic [CHECK_W-1:0] offset_of(input logic [1:0] slot);
      case (slot)
         SLOT_A: return OFFSET_A;
         SLOT_B: return OFFSET_B;
         SLOT_C: return OFFSET_C;
         default: return OFFSET_D;
      endcase
   endfunction

   // Long division of info * x^10 by the generator, one bit at a time
   function automatic logic [CHECK_W-1:0] calc_syndrome(input logic [INFO_W-1:0] info);
      logic [CHECK_W:0] rem;
      rem = '0;
      for (int b = INFO_W - 1; b >= 0; b--) begin
         rem = {rem[CHECK_W-1:0], info[b]};
         if (rem[CHECK_W]) begin
            rem = rem ^ 11'h5B9;
         end
      end
      for (int b = 0; b < CHECK_W; b++) begin
         rem = {rem[CHECK_W-1:0], 1'b0};
         if (rem[CHECK_W]) begin
            rem = rem ^ 11'h5B9;
         end
      end
      return rem[CHECK_W-1:0];
   endfunction

   function automatic logic [BLOCK_W-1:0] make_block(input logic [INFO_W-1:0] info,
                                                    input logic [1:0] slot);
      return {info, calc_syndrome(info) ^ offset_of(slot)};
   endfunction

   // Expected result of one accepted block; updates the group state
   function automatic void predict_block_result(input logic [BLOCK_W-1:0] word);
      blk_result_type r;
      logic [INFO_W-1:0]  info;
      logic [CHECK_W-1:0] rem;
      logic               hit;
      info = word[BLOCK_W-1:CHECK_W];
      rem = calc_syndrome(info);
      hit = 1'b0;
      r = '0;
      r.info = info;
      r.status = ST_CRC_FAIL;
      for (int s = 0; s < SLOTS; s++) begin
         if (!hit && (rem ^ offset_of(2'(s))) == word[CHECK_W-1:0]) begin
            hit = 1'b1;
            r.slot = 2'(s);
            r.status = ST_OK;
         end
      end
      if (!hit) begin
         grp_err = 1'b1;
      end else if (grp_slots[r.slot]) begin
         r.status = ST_DUP_SLOT;
         grp_err = 1'b1;
      end else begin
         grp_slots[r.slot] = 1'b1;
         if (r.slot == SLOT_B) begin
            grp_type_bits = info[INFO_W-1 -: TYPE_W];
         end
      end
      if (grp_count == LAST_BLOCK) begin
         r.done = 1'b1;
         if (grp_err) begin
            r.gtype = GT_ERROR;
         end else if (grp_type_bits == TYPE_CODE_0A) begin
            r.gtype = GT_0A;
         end else if (grp_type_bits == TYPE_CODE_2A) begin
            r.gtype = GT_2A;
         end else begin
            r.gtype = GT_UNKNOWN;
         end
         grp_count = '0;
         grp_slots = '0;
         grp_type_bits = '0;
         grp_err = 1'b0;
      end else begin
         grp_count = grp_count + 2'd1;
      end
      expected_results.insert(expected_results.size(), r);
   endfunction

   // Offer one item; valid stays high after accept unless a gap is taken
   task automatic send_block(input logic [BLOCK_W-1:0] word);
      req_valid <= 1'b1;
      req_block_word <= word;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predict_block_result(word);
      blocks_sent++;
      if (idle_on && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic sender_idle();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_all_results();
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Four blocks in a shuffled slot order; fault 1 corrupts one bit, 2 repeats a slot
   task automatic send_group(input logic [TYPE_W-1:0] tcode, input int fault);
      logic [1:0]         order [SLOTS];
      logic [1:0]         tmp;
      logic [INFO_W-1:0]  info;
      logic [BLOCK_W-1:0] word;
      int                 j;
      int                 bad;
      while (grp_count != 0) begin
         send_block(BLOCK_W'($urandom));
      end
      for (int i = 0; i < SLOTS; i++) begin
         order[i] = 2'(i);
      end
      for (int i = SLOTS - 1; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = order[i];
         order[i] = order[2'(j)];
         order[2'(j)] = tmp;
      end
      bad = $urandom_range(SLOTS - 1);
      if (fault == 2) begin
         order[2'(bad)] = order[2'((bad + 1) % SLOTS)];
      end
      for (int i = 0; i < SLOTS; i++) begin
         info = INFO_W'($urandom);
         if (order[i] == SLOT_B) begin
            info[INFO_W-1 -: TYPE_W] = tcode;
         end
         word = make_block(info, order[i]);
         if (fault == 1 && i == bad) begin
            word[5'($urandom_range(BLOCK_W - 1))] ^= 1'b1;
         end
         send_block(word);
      end
   endtask

   function automatic logic [TYPE_W-1:0] pick_type_code();
      case ($urandom_range(2))
         0: return TYPE_CODE_0A;
         1: return TYPE_CODE_2A;
         default: return TYPE_W'($urandom);
      endcase
   endfunction

   // Extremes, every slot, each group type, crc failure and duplicate slot
   task automatic test_directed();
      idle_on = 1'b1;
      // Unknown type: all-ones B block
      send_block(make_block(16'h0000, SLOT_A));
      send_block(make_block(16'hFFFF, SLOT_B));
      send_block(make_block(16'hFFFF, SLOT_C));
      send_block(make_block(16'h0000, SLOT_D));
      // Type 0A, reverse slot order
      send_block(make_block(16'hFFFF, SLOT_D));
      send_block(make_block(16'h1234, SLOT_C));
      send_block(make_block({TYPE_CODE_0A, 11'h7FF}, SLOT_B));
      send_block(make_block(16'h8001, SLOT_A));
      // Type 2A
      send_block(make_block({TYPE_CODE_2A, 11'h000}, SLOT_B));
      send_block(make_block(16'hA5A5, SLOT_A));
      send_block(make_block(16'h5A5A, SLOT_D));
      send_block(make_block(16'h0F0F, SLOT_C));
      // Crc failure: all check bits inverted, then all-ones word
      send_block(make_block(16'h0000, SLOT_A));
      send_block(make_block(16'hFFFF, SLOT_B) ^ 26'h3FF);
      send_block(26'h3FFFFFF);
      send_block(make_block({TYPE_CODE_2A, 11'h155}, SLOT_D));
      // Duplicate slot B: first block's type bits are kept, group flagged
      send_block(make_block({TYPE_CODE_0A, 11'h2AA}, SLOT_B));
      send_block(make_block(16'h7FFF, SLOT_A));
      send_block(make_block({TYPE_CODE_2A, 11'h001}, SLOT_B));
      send_block(make_block(16'h0001, SLOT_D));
      sender_idle();
      wait_all_results();
   endtask

   // Receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_result_backpressure();
      idle_on = 1'b0;
      hold_request = 80;
      for (int i = 0; i < 16; i++) begin
         send_group(pick_type_code(), 0);
      end
      sender_idle();
      wait_all_results();
   endtask

   // Sender pauses until every expected result has come, then resumes
   task automatic test_drain_pause();
      idle_on = 1'b1;
      for (int i = 0; i < 2; i++) begin
         send_group(pick_type_code(), 0);
      end
      send_block(BLOCK_W'($urandom));
      sender_idle();
      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      for (int i = 0; i < 3; i++) begin
         send_block(BLOCK_W'($urandom));
      end
      send_group(pick_type_code(), 0);
      sender_idle();
      wait_all_results();
   endtask

   // Mostly clean groups, some broken groups and raw random words
   task automatic test_random_traffic(input int n_items);
      int first;
      int mode;
      first = blocks_sent;
      while (blocks_sent - first < n_items) begin
         idle_on = (blocks_sent - first) >= n_items / 3;
         mode = $urandom_range(99);
         if (mode < 70) begin
            send_group(pick_type_code(), 0);
         end else if (mode < 85) begin
            send_group(pick_type_code(), $urandom_range(2, 1));
         end else begin
            send_block(BLOCK_W'($urandom));
         end
      end
      sender_idle();
      wait_all_results();
   endtask

   // Result side: long hold-off on request, else random stalls while idle_on is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(99) < 15) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic compare_field(input string name, input int expd, input int act);
      if (expd != act) begin
         $error("%s expected %0h actual %0h", name, expd, act);
         err_count++;
      end
   endtask

   // Result checker
   always @(posedge clock) begin
      blk_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected item: info_word %0h", rsp_info_word);
            err_count++;
         end else begin
            want = expected_results.pop_front();
            compare_field("info_word", int'(want.info), int'(rsp_info_word));
            compare_field("slot_position", int'(want.slot), int'(rsp_slot_position));
            compare_field("block_status", int'(want.status), int'(rsp_block_status));
            compare_field("group_done", int'(want.done), int'(rsp_group_done));
            compare_field("group_type", int'(want.gtype), int'(rsp_group_type));
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_result_backpressure();
      test_drain_pause();
      test_random_traffic(760);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0 && expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/rbo_pkg.sv
src/rds_block_offset_checker_core.sv
verif/tb_rds_block_offset_checker_core.sv
